@@ design/page_translate_lru_clean_first_top_defines.svh @@
// Assertion macros for the page translation block.
// Used by the files that carry concurrent checks; depends on i_clk and i_rst_n in scope.
`ifndef PAGE_TRANSLATE_LRU_CLEAN_FIRST_TOP_DEFINES_SVH
`define PAGE_TRANSLATE_LRU_CLEAN_FIRST_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTLCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTLCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ptlcf_pkg.sv @@
// Shared constants, payload types and helper functions for the page translation block.
// Has no dependencies; the top level and the core import it, ptlcf_ram does not.
package ptlcf_pkg;

    localparam int unsigned MAX_PAGES  = 64;
    localparam int unsigned MAX_FRAMES = 16;
    localparam int unsigned PAGE_BITS  = 12;
    localparam int unsigned TIME_BITS  = 32;

    localparam int unsigned VA_W   = 32;
    localparam int unsigned PA_W   = 16;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned NP_W   = 7;
    localparam int unsigned NF_W   = 5;
    localparam int unsigned CFG_W  = 7;

    localparam int unsigned PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned PC_W   = $clog2(MAX_PAGES + 1);
    localparam int unsigned FR_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned FC_W   = $clog2(MAX_FRAMES + 1);
    localparam int unsigned VPN_W  = VA_W - PAGE_BITS;
    localparam int unsigned ENT_W  = FR_W + TIME_BITS;

    typedef enum logic [0:0] {
        CFG_NUM_PAGES  = 1'b0,
        CFG_NUM_FRAMES = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic            func;
        logic [VA_W-1:0] virt_addr;
    } t_req;

    typedef struct packed {
        logic             addr_ok;
        logic [PA_W-1:0]  phys_addr;
        logic             page_fault;
        logic             replaced;
        logic             wrote_back;
        logic [CNT_W-1:0] load_total;
        logic [CNT_W-1:0] save_total;
        logic [CNT_W-1:0] replace_total;
    } t_rsp;

    typedef struct packed {
        logic [NP_W-1:0] num_pages;
        logic [NF_W-1:0] num_frames;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [TIME_BITS-1:0] time_inc(input logic [TIME_BITS-1:0] t);
        return (t == '1) ? t : t + TIME_BITS'(1);
    endfunction

    function automatic logic [PA_W-1:0] mk_phys(input logic [FR_W-1:0] fr,
                                                input logic [PAGE_BITS-1:0] off);
        logic [FR_W+PAGE_BITS-1:0] full;
        full = {fr, off};
        return PA_W'(full);
    endfunction

endpackage

@@ design/page_translate_lru_clean_first_top.sv @@
// Top level of the demand-paging translation block with clean-first LRU replacement.
// Depends on ptlcf_pkg and ptlcf_core (which holds the page memory).
//
//   Channel   Direction  Handshake                    Payload
//   request   in         i_req_valid / o_req_ready    i_req (t_req)
//   response  out        o_rsp_valid / i_rsp_ready    o_rsp (t_rsp)
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A request that hits passes from acceptance through the check and hit states to the result
// register; an out-of-range page is answered from the check state. A miss with a free frame
// probes the frames in turn, lowest first. A miss with every frame in use scans the whole
// page memory through its single read port, one entry a cycle, and then loads the page.
// Reset is synchronous and active low; residency and frame-use bits clear at once, so no
// clearing pass is needed. One request is in flight at a time; a result waits in the
// output register and the next request may be accepted while it is still pending.
module page_translate_lru_clean_first_top
    import ptlcf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic       r_rsp_valid;
    t_rsp       r_rsp;
    t_cfg       r_cfg, n_cfg;
    t_core_stat core_stat;
    t_rsp       core_rsp;
    logic       req_accept;
    logic       out_free;

    // The configuration registers take a write on any cycle.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_PAGES:  n_cfg.num_pages  = i_cfg_data[NP_W-1:0];
                CFG_NUM_FRAMES: n_cfg.num_frames = i_cfg_data[NF_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_pages  <= NP_W'(MAX_PAGES);
            r_cfg.num_frames <= NF_W'(MAX_FRAMES);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The sequencer takes a new request only when it is idle.
    assign o_req_ready = core_stat.idle;
    assign req_accept  = i_req_valid & o_req_ready;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !r_rsp_valid || i_rsp_ready;

    ptlcf_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (req_accept),
        .i_req      (i_req),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_stat     (core_stat),
        .o_rsp      (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (core_stat.done) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.done) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ design/ptlcf_ram.sv @@
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Generic; no package dependencies.
module ptlcf_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 36,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/ptlcf_core.sv @@
// Translation sequencer: residency bits, frame allocation, LRU victim scan and counters.
// Depends on ptlcf_pkg, ptlcf_ram and the assertion macro header.
`include "page_translate_lru_clean_first_top_defines.svh"

module ptlcf_core
    import ptlcf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_req       i_req,
    input  t_cfg       i_cfg,
    input  logic       i_out_free,
    output t_core_stat o_stat,
    output t_rsp       o_rsp
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_HIT   = 6'b000100,
        ST_FSCAN = 6'b001000,
        ST_VSCAN = 6'b010000,
        ST_LOAD  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_func, n_func;
    logic [VA_W-1:0]       r_va, n_va;
    logic [MAX_PAGES-1:0]  r_res, n_res;
    logic [MAX_PAGES-1:0]  r_dirty, n_dirty;
    logic [MAX_FRAMES-1:0] r_used, n_used;
    logic [TIME_BITS-1:0]  r_time, n_time;
    logic [CNT_W-1:0]      r_loads, n_loads;
    logic [CNT_W-1:0]      r_saves, n_saves;
    logic [CNT_W-1:0]      r_repl, n_repl;
    logic [FC_W-1:0]       r_fidx, n_fidx;
    logic [FR_W-1:0]       r_frame, n_frame;
    logic [PG_W-1:0]       r_victim, n_victim;
    logic                  r_wb, n_wb;
    logic                  r_evict, n_evict;
    logic [PC_W-1:0]       r_scan, n_scan;
    logic                  r_rd_vld, n_rd_vld;
    logic [PG_W-1:0]       r_rd_idx, n_rd_idx;
    logic                  r_bc_vld, n_bc_vld;
    logic [PG_W-1:0]       r_bc_idx, n_bc_idx;
    logic [TIME_BITS-1:0]  r_bc_stamp, n_bc_stamp;
    logic [FR_W-1:0]       r_bc_frame, n_bc_frame;
    logic                  r_bd_vld, n_bd_vld;
    logic [PG_W-1:0]       r_bd_idx, n_bd_idx;
    logic [TIME_BITS-1:0]  r_bd_stamp, n_bd_stamp;
    logic [FR_W-1:0]       r_bd_frame, n_bd_frame;

    logic [VPN_W-1:0]      vpn;
    logic [PAGE_BITS-1:0]  offs;
    logic [PG_W-1:0]       pg;
    logic [VPN_W-1:0]      np_eff;
    logic [FC_W-1:0]       nf_eff;
    logic                  page_ok;
    logic                  scan_more;
    logic [FR_W-1:0]       fidx_lo;
    logic [FR_W-1:0]       rd_frame;
    logic [TIME_BITS-1:0]  rd_stamp;

    logic                  rd_en;
    logic [PG_W-1:0]       rd_addr;
    logic                  wr_en;
    logic [ENT_W-1:0]      wr_data;
    logic [ENT_W-1:0]      rd_data;
    logic                  done;
    t_rsp                  rsp;

    assign vpn      = r_va[VA_W-1:PAGE_BITS];
    assign offs     = r_va[PAGE_BITS-1:0];
    assign pg       = vpn[PG_W-1:0];
    assign fidx_lo  = r_fidx[FR_W-1:0];
    assign rd_frame = rd_data[ENT_W-1 -: FR_W];
    assign rd_stamp = rd_data[TIME_BITS-1:0];
    assign scan_more = (r_scan < PC_W'(MAX_PAGES));

    always_comb begin
        if (VPN_W'(i_cfg.num_pages) > VPN_W'(MAX_PAGES)) begin
            np_eff = VPN_W'(MAX_PAGES);
        end else begin
            np_eff = VPN_W'(i_cfg.num_pages);
        end
        if (32'(i_cfg.num_frames) > 32'(MAX_FRAMES)) begin
            nf_eff = FC_W'(MAX_FRAMES);
        end else if (i_cfg.num_frames == '0) begin
            nf_eff = FC_W'(1);
        end else begin
            nf_eff = FC_W'(i_cfg.num_frames);
        end
    end

    assign page_ok = (vpn < np_eff);

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_va       = r_va;
        n_res      = r_res;
        n_dirty    = r_dirty;
        n_used     = r_used;
        n_time     = r_time;
        n_loads    = r_loads;
        n_saves    = r_saves;
        n_repl     = r_repl;
        n_fidx     = r_fidx;
        n_frame    = r_frame;
        n_victim   = r_victim;
        n_wb       = r_wb;
        n_evict    = r_evict;
        n_scan     = r_scan;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_bc_vld   = r_bc_vld;
        n_bc_idx   = r_bc_idx;
        n_bc_stamp = r_bc_stamp;
        n_bc_frame = r_bc_frame;
        n_bd_vld   = r_bd_vld;
        n_bd_idx   = r_bd_idx;
        n_bd_stamp = r_bd_stamp;
        n_bd_frame = r_bd_frame;
        rd_en      = 1'b0;
        rd_addr    = pg;
        wr_en      = 1'b0;
        wr_data    = {r_frame, r_time};
        done       = 1'b0;
        rsp        = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_func  = i_req.func;
                    n_va    = i_req.virt_addr;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!page_ok) begin
                    if (i_out_free) begin
                        done    = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (r_res[pg]) begin
                    rd_en   = 1'b1;
                    n_state = ST_HIT;
                end else begin
                    n_fidx  = '0;
                    n_state = ST_FSCAN;
                end
            end
            ST_HIT: begin
                if (i_out_free) begin
                    wr_en         = 1'b1;
                    wr_data       = {rd_frame, r_time};
                    n_dirty[pg]   = r_dirty[pg] | r_func;
                    n_time        = time_inc(r_time);
                    done          = 1'b1;
                    rsp.addr_ok   = 1'b1;
                    rsp.phys_addr = mk_phys(rd_frame, offs);
                    n_state       = ST_IDLE;
                end
            end
            ST_FSCAN: begin
                if (r_fidx == nf_eff) begin
                    n_scan   = '0;
                    n_bc_vld = 1'b0;
                    n_bd_vld = 1'b0;
                    n_state  = ST_VSCAN;
                end else if (!r_used[fidx_lo]) begin
                    n_frame = fidx_lo;
                    n_evict = 1'b0;
                    n_wb    = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    n_fidx = r_fidx + FC_W'(1);
                end
            end
            ST_VSCAN: begin
                if (scan_more) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_scan[PG_W-1:0];
                    n_scan   = r_scan + PC_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan[PG_W-1:0];
                end
                if (r_rd_vld && r_res[r_rd_idx]) begin
                    if (!r_dirty[r_rd_idx]) begin
                        if (!r_bc_vld || (rd_stamp < r_bc_stamp)) begin
                            n_bc_vld   = 1'b1;
                            n_bc_idx   = r_rd_idx;
                            n_bc_stamp = rd_stamp;
                            n_bc_frame = rd_frame;
                        end
                    end else begin
                        if (!r_bd_vld || (rd_stamp < r_bd_stamp)) begin
                            n_bd_vld   = 1'b1;
                            n_bd_idx   = r_rd_idx;
                            n_bd_stamp = rd_stamp;
                            n_bd_frame = rd_frame;
                        end
                    end
                end
                if (!scan_more && !r_rd_vld) begin
                    if (r_bc_vld) begin
                        n_victim = r_bc_idx;
                        n_frame  = r_bc_frame;
                        n_wb     = 1'b0;
                    end else begin
                        n_victim = r_bd_idx;
                        n_frame  = r_bd_frame;
                        n_wb     = 1'b1;
                    end
                    n_evict = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_out_free) begin
                    if (r_evict) begin
                        n_res[r_victim]   = 1'b0;
                        n_dirty[r_victim] = 1'b0;
                        n_repl            = sat_inc(r_repl);
                    end
                    if (r_wb) begin
                        n_saves = sat_inc(r_saves);
                    end
                    n_used[r_frame] = 1'b1;
                    n_res[pg]       = 1'b1;
                    n_dirty[pg]     = r_func;
                    n_loads         = sat_inc(r_loads);
                    n_time          = time_inc(r_time);
                    wr_en           = 1'b1;
                    done            = 1'b1;
                    rsp.addr_ok     = 1'b1;
                    rsp.phys_addr   = mk_phys(r_frame, offs);
                    rsp.page_fault  = 1'b1;
                    rsp.replaced    = r_evict;
                    rsp.wrote_back  = r_wb;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        rsp.load_total    = n_loads;
        rsp.save_total    = n_saves;
        rsp.replace_total = n_repl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_res    <= '0;
            r_dirty  <= '0;
            r_used   <= '0;
            r_time   <= '0;
            r_loads  <= '0;
            r_saves  <= '0;
            r_repl   <= '0;
            r_rd_vld <= 1'b0;
            r_bc_vld <= 1'b0;
            r_bd_vld <= 1'b0;
            r_evict  <= 1'b0;
            r_wb     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_res    <= n_res;
            r_dirty  <= n_dirty;
            r_used   <= n_used;
            r_time   <= n_time;
            r_loads  <= n_loads;
            r_saves  <= n_saves;
            r_repl   <= n_repl;
            r_rd_vld <= n_rd_vld;
            r_bc_vld <= n_bc_vld;
            r_bd_vld <= n_bd_vld;
            r_evict  <= n_evict;
            r_wb     <= n_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_va       <= n_va;
        r_fidx     <= n_fidx;
        r_frame    <= n_frame;
        r_victim   <= n_victim;
        r_scan     <= n_scan;
        r_rd_idx   <= n_rd_idx;
        r_bc_idx   <= n_bc_idx;
        r_bc_stamp <= n_bc_stamp;
        r_bc_frame <= n_bc_frame;
        r_bd_idx   <= n_bd_idx;
        r_bd_stamp <= n_bd_stamp;
        r_bd_frame <= n_bd_frame;
    end

    // Page memory: frame number and last-access stamp of every page.
    ptlcf_ram #(
        .DEPTH (MAX_PAGES),
        .WIDTH (ENT_W)
    ) u_page_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (pg),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = done;
    assign o_rsp       = rsp;

    `PTLCF_ASSERT_SAME(a_hit_resident, r_state == ST_HIT, r_res[pg],
        "hit path entered for a page that is not resident")
    `PTLCF_ASSERT_SAME(a_load_absent, r_state == ST_LOAD, !r_res[pg],
        "load path entered for a page that is already resident")
    `PTLCF_ASSERT_SAME(a_victim_found, (r_state == ST_VSCAN) && !scan_more && !r_rd_vld,
        r_bc_vld || r_bd_vld, "victim scan finished without a resident page")
    `PTLCF_ASSERT_SAME(a_evict_frame_used, (r_state == ST_LOAD) && r_evict, r_used[r_frame],
        "evicted page owned a frame that is marked free")
    `PTLCF_ASSERT_SAME(a_done_slot_free, o_stat.done, i_out_free,
        "result produced while the output register is still full")

endmodule

@@ tb/sv/page_translate_lru_clean_first_top_tb.sv @@
// Self-checking testbench for page_translate_lru_clean_first_top: demand-paged translation
// with clean-first LRU replacement. Depends on ptlcf_pkg and the design files it imports.
// A behavioral predictor computes each response at request acceptance.
`timescale 1ns / 100ps

module page_translate_lru_clean_first_top_tb;
    import ptlcf_pkg::*;

    // Access kinds carried in the func field of a request.
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    // Idle patterns for the two handshakes.
    localparam int IDLE_SEND_LIGHT = 0;  // sender idles 36%, receiver 81%
    localparam int IDLE_RECV_LIGHT = 1;  // sender idles 81%, receiver 36%
    localparam int IDLE_NONE       = 2;

    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int HOLD_AT_REQ    = 120;  // request count that starts the long receiver stall
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQS     = 94;
    localparam int MAX_REPORTED   = 10;

    // Residency of one virtual page in the predictor.
    typedef enum logic [1:0] {
        PG_ABSENT = 2'd0,
        PG_CLEAN  = 2'd1,
        PG_DIRTY  = 2'd2
    } t_pg_state;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_req_valid = 1'b0;
    logic             o_req_ready;
    t_req             i_req       = '0;
    logic             o_rsp_valid;
    logic             i_rsp_ready = 1'b0;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    t_cfg_idx         i_cfg_index = CFG_NUM_PAGES;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    page_translate_lru_clean_first_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: a private copy of the page table, frame usage, the access clock,
    // the running totals and the two configuration registers.
    t_pg_state            pg_state   [MAX_PAGES];
    logic [FR_W-1:0]      pg_frame   [MAX_PAGES];
    logic [TIME_BITS-1:0] pg_stamp   [MAX_PAGES];
    logic                 frame_busy [MAX_FRAMES];
    logic [TIME_BITS-1:0] clock_now;
    logic [CNT_W-1:0]     load_cnt;
    logic [CNT_W-1:0]     save_cnt;
    logic [CNT_W-1:0]     replace_cnt;
    logic [NP_W-1:0]      model_pages;
    logic [NF_W-1:0]      model_frames;

    // Requests waiting to be offered, and responses predicted but not yet seen.
    t_req access_queue [$];
    t_rsp rsp_due      [$];

    int idle_mode      = IDLE_SEND_LIGHT;
    int accepted_total = 0;
    int queued_total   = 0;
    int rsp_seen       = 0;
    int mismatches     = 0;
    int hold_left      = 0;
    bit hold_used      = 1'b0;
    int cycle_cnt      = 0;

    // Register settings for the random phases; both registers reach their largest value, and the frame count also zero.
    int unsigned phase_pages  [RANDOM_PHASES] = '{64, 8, 127, 20, 64, 3, 33, 1};
    int unsigned phase_frames [RANDOM_PHASES] = '{16, 4, 31, 2, 8, 1, 16, 0};

    // Least recently stamped page in the given state, lowest page number on a tie; -1 if none.
    // The search spans every page entry, not only those below the page count.
    function automatic int oldest_page(input t_pg_state want);
        int best;
        best = -1;
        for (int p = 0; p < MAX_PAGES; p++) begin
            if (pg_state[p] == want && (best < 0 || pg_stamp[p] < pg_stamp[best])) begin
                best = p;
            end
        end
        return best;
    endfunction

    // Applies one access to the predictor state and returns the response it must produce.
    function automatic t_rsp translate_access(input t_req acc);
        t_rsp             res;
        logic [VPN_W-1:0] vpn;
        int unsigned      np;
        int unsigned      nf;
        int unsigned      pg;
        int               fr;
        int               victim;
        res = '0;
        vpn = acc.virt_addr[VA_W-1:PAGE_BITS];
        // Counts above the maximum act as the maximum; a frame count of zero acts as one.
        np  = (model_pages > MAX_PAGES) ? MAX_PAGES : model_pages;
        nf  = (model_frames > MAX_FRAMES) ? MAX_FRAMES : model_frames;
        if (nf == 0) begin
            nf = 1;
        end
        res.addr_ok = (vpn < np);
        if (res.addr_ok) begin
            pg = 32'(vpn);
            if (pg_state[pg] == PG_ABSENT) begin
                fr = -1;
                for (int f = 0; f < nf; f++) begin
                    if (fr < 0 && !frame_busy[f]) begin
                        fr = f;
                    end
                end
                if (fr < 0) begin
                    // No free frame: evict the oldest clean page, else the oldest dirty one.
                    victim = oldest_page(PG_CLEAN);
                    if (victim < 0) begin
                        victim = oldest_page(PG_DIRTY);
                    end
                    res.replaced = 1'b1;
                    if (replace_cnt != '1) begin
                        replace_cnt = replace_cnt + 1'b1;
                    end
                    if (pg_state[victim] == PG_DIRTY) begin
                        res.wrote_back = 1'b1;
                        if (save_cnt != '1) begin
                            save_cnt = save_cnt + 1'b1;
                        end
                    end
                    fr = 32'(pg_frame[victim]);
                    pg_state[victim] = PG_ABSENT;
                    frame_busy[fr]   = 1'b0;
                end
                res.page_fault = 1'b1;
                if (load_cnt != '1) begin
                    load_cnt = load_cnt + 1'b1;
                end
                pg_state[pg]   = PG_CLEAN;
                pg_frame[pg]   = FR_W'(fr);
                frame_busy[fr] = 1'b1;
            end
            if (acc.func == ACC_WRITE) begin
                pg_state[pg] = PG_DIRTY;
            end
            pg_stamp[pg] = clock_now;
            if (clock_now != '1) begin
                clock_now = clock_now + 1'b1;
            end
            res.phys_addr = PA_W'({pg_frame[pg], acc.virt_addr[PAGE_BITS-1:0]});
        end
        res.load_total    = load_cnt;
        res.save_total    = save_cnt;
        res.replace_total = replace_cnt;
        return res;
    endfunction

    // Mostly well-formed accesses with locality so that hits, free-frame misses and both kinds
    // of eviction all occur; the rest lands near or past the page count, or anywhere at all.
    function automatic t_req random_access();
        t_req           acc;
        int unsigned    np;
        int unsigned    page;
        int unsigned    roll;
        logic [PAGE_BITS-1:0] offset;
        np     = (model_pages > MAX_PAGES) ? MAX_PAGES : model_pages;
        roll   = $urandom_range(0, 99);
        offset = PAGE_BITS'($urandom_range(0, (1 << PAGE_BITS) - 1));
        acc.func = ($urandom_range(0, 1) != 0) ? ACC_WRITE : ACC_READ;
        if (roll < 8) begin
            acc.virt_addr = $urandom();
        end else begin
            if (roll < 18 || np == 0) begin
                page = $urandom_range(0, 2 * MAX_PAGES - 1);
            end else if (roll < 60) begin
                page = $urandom_range(0, (np - 1) / 3);
            end else begin
                page = $urandom_range(0, np - 1);
            end
            acc.virt_addr = {VPN_W'(page), offset};
        end
        return acc;
    endfunction

    task automatic check_field(input string fname, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
                $display("response %0d: %s expected 0x%0h, got 0x%0h",
                         rsp_seen, fname, want, got);
            end
        end
    endtask

    task automatic queue_access(input logic kind, input logic [VA_W-1:0] addr);
        t_req acc;
        acc.func      = kind;
        acc.virt_addr = addr;
        access_queue.push_back(acc);
        queued_total++;
    endtask

    // Register writes happen only while the block is idle, so the predictor takes the new
    // value at the same edge as the block.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        if (idx == CFG_NUM_PAGES) begin
            model_pages = value[NP_W-1:0];
        end else begin
            model_frames = value[NF_W-1:0];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Holds the sender back until every queued request has been accepted and every
    // predicted response has come back. Each request yields exactly one response, so the
    // block is idle at that point; spare cycles are added anyway.
    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (access_queue.size() != 0 || i_req_valid || rsp_due.size() != 0 ||
                   rsp_seen != queued_total);
        repeat (8) @(posedge i_clk);
    endtask

    // Request driver. On acceptance the request goes through the predictor and its response
    // joins the back of the due list. A new request is then offered unless the sender idles.
    // Valid is assigned at most once per edge, so a back-to-back request never sees a
    // momentary low.
    always @(posedge i_clk) begin : req_driver
        logic taken;
        logic offer;
        int   pct;
        taken = i_req_valid && o_req_ready;
        if (taken) begin
            rsp_due.push_back(translate_access(i_req));
            accepted_total <= accepted_total + 1;
        end
        if (!i_req_valid || taken) begin
            pct   = (idle_mode == IDLE_SEND_LIGHT) ? 36 : (idle_mode == IDLE_RECV_LIGHT) ? 81 : 0;
            offer = i_rst_n && access_queue.size() != 0 && $urandom_range(0, 99) >= pct;
            if (offer) begin
                i_req <= access_queue.pop_front();
            end
            i_req_valid <= offer;
        end
    end

    // Long receiver stall, counted here. It starts once a fixed number of requests has been
    // accepted, while the sender still has plenty queued, so the output register and the
    // single in-flight slot fill up and the block must drop its request ready.
    always @(posedge i_clk) begin : rsp_hold
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && accepted_total == HOLD_AT_REQ) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Response monitor. Every accepted response is compared, field by field, with the oldest
    // prediction; a response with nothing predicted is an error of its own.
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        int   pct;
        if (o_rsp_valid && i_rsp_ready) begin
            if (rsp_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED) begin
                    $display("response %0d arrived with no request outstanding: 0x%0h",
                             rsp_seen, o_rsp);
                end
            end else begin
                want = rsp_due.pop_front();
                check_field("addr_ok",       CNT_W'(o_rsp.addr_ok),    CNT_W'(want.addr_ok));
                check_field("phys_addr",     CNT_W'(o_rsp.phys_addr),  CNT_W'(want.phys_addr));
                check_field("page_fault",    CNT_W'(o_rsp.page_fault), CNT_W'(want.page_fault));
                check_field("replaced",      CNT_W'(o_rsp.replaced),   CNT_W'(want.replaced));
                check_field("wrote_back",    CNT_W'(o_rsp.wrote_back), CNT_W'(want.wrote_back));
                check_field("load_total",    o_rsp.load_total,    want.load_total);
                check_field("save_total",    o_rsp.save_total,    want.save_total);
                check_field("replace_total", o_rsp.replace_total, want.replace_total);
            end
            rsp_seen++;
        end
        pct = (idle_mode == IDLE_SEND_LIGHT) ? 81 : (idle_mode == IDLE_RECV_LIGHT) ? 36 : 0;
        i_rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        // Predictor reset mirrors the block's: nothing resident, clocks and totals at zero,
        // and both registers at their maximum.
        for (int p = 0; p < MAX_PAGES; p++) begin
            pg_state[p] = PG_ABSENT;
            pg_frame[p] = '0;
            pg_stamp[p] = '0;
        end
        for (int f = 0; f < MAX_FRAMES; f++) begin
            frame_busy[f] = 1'b0;
        end
        clock_now    = '0;
        load_cnt     = '0;
        save_cnt     = '0;
        replace_cnt  = '0;
        model_pages  = NP_W'(MAX_PAGES);
        model_frames = NF_W'(MAX_FRAMES);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: free-frame misses, a hit that dirties a page,
        // the last valid page with the top offset, the first page past the count, and the
        // all-ones address.
        queue_access(ACC_READ,  32'h0000_0000);
        queue_access(ACC_WRITE, 32'h0000_0FFF);
        queue_access(ACC_READ,  32'h0003_FFFF);
        queue_access(ACC_WRITE, 32'h0004_0000);
        queue_access(ACC_READ,  32'hFFFF_FFFF);
        queue_access(ACC_WRITE, 32'h0000_1ABC);
        drain();

        // A page count of zero turns every access invalid, resident pages included.
        write_reg(CFG_NUM_PAGES,  7'd0);
        write_reg(CFG_NUM_FRAMES, 7'd0);
        queue_access(ACC_READ,  32'h0000_0000);
        queue_access(ACC_WRITE, 32'h0000_0FFF);
        drain();

        // An oversized page count acts as the maximum, and a frame count of zero acts as one:
        // frame 0 is taken, so every miss evicts. A clean page goes first; once only dirty
        // pages remain, the oldest dirty one is written back.
        write_reg(CFG_NUM_PAGES, 7'd127);
        queue_access(ACC_READ,  32'h0000_5555);
        queue_access(ACC_WRITE, 32'h0004_0010);
        queue_access(ACC_READ,  32'h0000_2000);
        queue_access(ACC_WRITE, 32'h0000_2FFF);
        queue_access(ACC_READ,  32'h0000_7001);
        queue_access(ACC_READ,  32'h0000_0800);
        drain();

        // Shrunk page count with an oversized frame count: page 1 is still resident but is
        // now out of range.
        write_reg(CFG_NUM_PAGES,  7'd1);
        write_reg(CFG_NUM_FRAMES, 7'd31);
        queue_access(ACC_READ,  32'h0000_0ABC);
        queue_access(ACC_WRITE, 32'h0000_1000);
        queue_access(ACC_WRITE, 32'h0000_0000);
        drain();

        // Back to full range: the page left resident hits, and a new page takes a free frame.
        write_reg(CFG_NUM_PAGES,  7'd64);
        write_reg(CFG_NUM_FRAMES, 7'd16);
        queue_access(ACC_READ,  32'h0000_1234);
        queue_access(ACC_WRITE, 32'h0000_9FFF);
        drain();

        // Random part, one register setting per phase. The idle pattern moves from a busy
        // sender to a busy receiver to no idling at all. Each phase ends with the sender
        // paused until every response is back, which is also when the registers change.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_mode = (ph < 3) ? IDLE_SEND_LIGHT : (ph < 6) ? IDLE_RECV_LIGHT : IDLE_NONE;
            write_reg(CFG_NUM_PAGES,  CFG_W'(phase_pages[ph]));
            write_reg(CFG_NUM_FRAMES, CFG_W'(phase_frames[ph]));
            for (int k = 0; k < PHASE_REQS; k++) begin
                access_queue.push_back(random_access());
                queued_total++;
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && rsp_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
